FILE: design/shba_pkg.sv
// ----------------------------------------------------------------------------
// Salted handle block allocator package
// Shared sizes, operation codes and status codes.
// ----------------------------------------------------------------------------
`default_nettype none

package shba_pkg;

  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned IDX_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = IDX_W + 1;
  localparam int unsigned SALT_W     = 16;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_FREE  = 2'd1;
  localparam logic [1:0] OP_GET   = 2'd2;

  localparam logic [1:0] CFG_BLOCK_COUNT = 2'd0;
  localparam logic [1:0] CFG_BLOCK_SIZE  = 2'd1;
  localparam logic [1:0] CFG_DATA_OFFSET = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_EXHAUSTED = 3'd2;
  localparam logic [2:0] ST_SALT      = 3'd3;
  localparam logic [2:0] ST_INVALID   = 3'd4;
  localparam logic [2:0] ST_NOT_FOUND = 3'd5;

endpackage

`default_nettype wire

FILE: design/shba_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module shba_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: design/salted_handle_block_allocator.sv
// ----------------------------------------------------------------------------
// Salted handle block allocator
// Fixed-size block allocator with an occupancy map in flops and a salt
// table in a synchronous RAM, scanned one entry per cycle.
// ----------------------------------------------------------------------------
// A refused request goes straight to the result; any other request scans the
// blocks in turn until a salt hit or the last active block, and a get-address
// hit adds an address step before the result is presented.
// One request at a time; a new beat can be taken in the same cycle that the
// result is presented.
// Reset clears the occupancy map at once, the count to zero and the handle
// counter to one; the salt RAM needs no clearing pass.
`default_nettype none

module salted_handle_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [31:0] handle_i,
  input  wire logic [15:0] salt_candidate_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic      [2:0]  status_o,
  output logic      [31:0] new_handle_o,
  output logic      [7:0]  block_index_o,
  output logic      [31:0] block_address_o,
  output logic      [8:0]  allocated_count_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [20:0] cfg_data_i
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_ADDR,
    S_DONE
  } state_e;

  localparam int unsigned IW = shba_pkg::IDX_W;
  localparam int unsigned CW = shba_pkg::CNT_W;

  state_e state_q;
  logic [8:0]  block_count_q;
  logic [16:0] block_size_q;
  logic [20:0] data_offset_q;
  logic [shba_pkg::MAX_BLOCKS-1:0] occ_q;
  logic [CW-1:0] total_q;
  logic [31:0]   ctr_q;
  logic [1:0]    op_q;
  logic [15:0]   tgt_q;
  logic [CW-1:0] cnt_q;
  logic          pend_q;
  logic [IW-1:0] pidx_q;
  logic          occ_rd_q;
  logic          free_found_q;
  logic [IW-1:0] free_idx_q;
  logic [2:0]    res_status_q;
  logic [IW-1:0] res_idx_q;
  logic [31:0]   res_addr_q;

  logic [CW-1:0] active_n;
  logic          issue;
  logic [15:0]   rdata;
  logic          hit;
  logic          out_free;
  logic          ram_we;
  logic [24:0]   prod;

  assign active_n = (32'(block_count_q) > shba_pkg::MAX_BLOCKS) ?
                    CW'(shba_pkg::MAX_BLOCKS) : CW'(block_count_q);
  assign issue    = (state_q == S_SCAN) && (cnt_q < active_n);
  assign hit      = pend_q && occ_rd_q && (rdata == tgt_q);
  assign out_free = !out_valid_o || out_ready_i;
  assign ram_we   = (state_q == S_DONE) && out_free &&
                    (res_status_q == shba_pkg::ST_OK) && (op_q == shba_pkg::OP_ALLOC);
  assign prod     = 25'(res_idx_q) * 25'(block_size_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  shba_ram #(
    .WIDTH(shba_pkg::SALT_W),
    .DEPTH(shba_pkg::MAX_BLOCKS)
  ) u_salt_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(res_idx_q),
    .wdata_i(tgt_q),
    .re_i   (issue),
    .raddr_i(cnt_q[IW-1:0]),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q           <= S_IDLE;
      block_count_q     <= 9'd256;
      block_size_q      <= 17'd64;
      data_offset_q     <= '0;
      occ_q             <= '0;
      total_q           <= '0;
      ctr_q             <= 32'd1;
      pend_q            <= 1'b0;
      out_valid_o       <= 1'b0;
      op_q              <= '0;
      tgt_q             <= '0;
      cnt_q             <= '0;
      pidx_q            <= '0;
      occ_rd_q          <= 1'b0;
      free_found_q      <= 1'b0;
      free_idx_q        <= '0;
      res_status_q      <= '0;
      res_idx_q         <= '0;
      res_addr_q        <= '0;
      status_o          <= '0;
      new_handle_o      <= '0;
      block_index_o     <= '0;
      block_address_o   <= '0;
      allocated_count_o <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          shba_pkg::CFG_BLOCK_COUNT: block_count_q <= cfg_data_i[8:0];
          shba_pkg::CFG_BLOCK_SIZE:  block_size_q  <= cfg_data_i[16:0];
          shba_pkg::CFG_DATA_OFFSET: data_offset_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_o && out_ready_i) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= operation_i;
            cnt_q        <= '0;
            pend_q       <= 1'b0;
            free_found_q <= 1'b0;
            res_idx_q    <= '0;
            res_addr_q   <= '0;
            state_q      <= S_DONE;
            if (operation_i == shba_pkg::OP_ALLOC) begin
              tgt_q <= salt_candidate_i;
              if (total_q >= active_n) begin
                res_status_q <= shba_pkg::ST_FULL;
              end else if (ctr_q == 32'd0) begin
                res_status_q <= shba_pkg::ST_EXHAUSTED;
              end else if (salt_candidate_i == 16'd0) begin
                res_status_q <= shba_pkg::ST_SALT;
              end else begin
                state_q <= S_SCAN;
              end
            end else if (operation_i == shba_pkg::OP_FREE ||
                         operation_i == shba_pkg::OP_GET) begin
              tgt_q <= handle_i[31:16];
              if (handle_i == 32'd0) begin
                res_status_q <= shba_pkg::ST_INVALID;
              end else begin
                state_q <= S_SCAN;
              end
            end else begin
              res_status_q <= shba_pkg::ST_INVALID;
            end
          end
        end
        S_SCAN: begin
          pend_q <= issue;
          pidx_q <= cnt_q[IW-1:0];
          if (issue) begin
            cnt_q    <= cnt_q + CW'(1);
            occ_rd_q <= occ_q[cnt_q[IW-1:0]];
          end
          if (pend_q && !free_found_q && !occ_rd_q) begin
            free_found_q <= 1'b1;
            free_idx_q   <= pidx_q;
          end
          if (hit) begin
            pend_q <= 1'b0;
            if (op_q == shba_pkg::OP_ALLOC) begin
              res_status_q <= shba_pkg::ST_SALT;
              state_q      <= S_DONE;
            end else begin
              res_status_q <= shba_pkg::ST_OK;
              res_idx_q    <= pidx_q;
              state_q      <= (op_q == shba_pkg::OP_GET) ? S_ADDR : S_DONE;
            end
          end else if (!issue && !pend_q) begin
            state_q <= S_DONE;
            if (op_q == shba_pkg::OP_ALLOC) begin
              res_status_q <= shba_pkg::ST_OK;
              res_idx_q    <= free_idx_q;
            end else begin
              res_status_q <= shba_pkg::ST_NOT_FOUND;
            end
          end
        end
        S_ADDR: begin
          res_addr_q <= 32'(data_offset_q) + 32'(prod);
          state_q    <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_o     <= 1'b1;
            status_o        <= res_status_q;
            block_index_o   <= 8'(res_idx_q);
            block_address_o <= res_addr_q;
            new_handle_o    <= '0;
            allocated_count_o <= 9'(total_q);
            if (res_status_q == shba_pkg::ST_OK) begin
              if (op_q == shba_pkg::OP_ALLOC) begin
                occ_q[res_idx_q]  <= 1'b1;
                total_q           <= total_q + CW'(1);
                allocated_count_o <= 9'(total_q + CW'(1));
                new_handle_o      <= {tgt_q, 16'd0} | ctr_q;
                ctr_q             <= ctr_q + 32'd1;
              end else if (op_q == shba_pkg::OP_FREE) begin
                occ_q[res_idx_q] <= 1'b0;
                if (total_q != '0) begin
                  total_q           <= total_q - CW'(1);
                  allocated_count_o <= 9'(total_q - CW'(1));
                end
              end
            end
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// Salted handle block allocator testbench
// Drives allocate, free, get-address and invalid requests with random handshake gaps,
// predicts every response from a behavioral model of the pool and checks
// each output beat field by field, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

class alloc_scoreboard;
  bit          used [shba_pkg::MAX_BLOCKS];
  logic [15:0] salts [shba_pkg::MAX_BLOCKS];
  int unsigned total;
  logic [31:0] counter;
  int unsigned blk_count;
  logic [16:0] blk_size;
  logic [20:0] base_offset;
  logic [2:0]  exp_status [$];
  logic [31:0] exp_handle [$];
  logic [7:0]  exp_index [$];
  logic [31:0] exp_addr [$];
  logic [8:0]  exp_total [$];
  int          errors;

  function new();
    foreach (used[i]) begin
      used[i] = 0;
      salts[i] = '0;
    end
    total = 0;
    counter = 32'd1;
    blk_count = 256;
    blk_size = 17'd64;
    base_offset = '0;
    errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [20:0] data);
    case (idx)
      shba_pkg::CFG_BLOCK_COUNT: blk_count = data[8:0];
      shba_pkg::CFG_BLOCK_SIZE:  blk_size = data[16:0];
      shba_pkg::CFG_DATA_OFFSET: base_offset = data;
      default: ;
    endcase
  endfunction

  function int unsigned active();
    return blk_count > shba_pkg::MAX_BLOCKS ? shba_pkg::MAX_BLOCKS : blk_count;
  endfunction

  function int find_salt(logic [15:0] s);
    for (int i = 0; i < active(); i++)
      if (used[i] && salts[i] == s) return i;
    return -1;
  endfunction

  function bit salt_taken(logic [15:0] s);
    return find_salt(s) >= 0;
  endfunction

  function void note_request(logic [1:0] op, logic [31:0] h, logic [15:0] cand);
    logic [2:0]  st;
    logic [31:0] nh;
    logic [31:0] addr;
    logic [63:0] sum;
    int          idx;
    int          f;
    st = shba_pkg::ST_INVALID;
    nh = '0;
    addr = '0;
    idx = 0;
    if (op == shba_pkg::OP_ALLOC) begin
      if (total >= active()) st = shba_pkg::ST_FULL;
      else if (counter == 0) st = shba_pkg::ST_EXHAUSTED;
      else if (cand == 0 || find_salt(cand) >= 0) st = shba_pkg::ST_SALT;
      else begin
        for (int i = 0; i < active(); i++)
          if (!used[i]) begin
            idx = i;
            break;
          end
        salts[idx] = cand;
        used[idx] = 1;
        total++;
        nh = {cand, 16'h0} | counter;
        counter++;
        st = shba_pkg::ST_OK;
      end
    end else if (op == shba_pkg::OP_FREE || op == shba_pkg::OP_GET) begin
      if (h == 0) st = shba_pkg::ST_INVALID;
      else begin
        f = find_salt(h[31:16]);
        if (f < 0) st = shba_pkg::ST_NOT_FOUND;
        else begin
          idx = f;
          st = shba_pkg::ST_OK;
          if (op == shba_pkg::OP_FREE) begin
            used[idx] = 0;
            if (total > 0) total--;
          end else begin
            sum = 64'(base_offset) + 64'(idx) * 64'(blk_size);
            addr = sum[31:0];
          end
        end
      end
    end
    exp_status.push_back(st);
    exp_handle.push_back(nh);
    exp_index.push_back(idx[7:0]);
    exp_addr.push_back(addr);
    exp_total.push_back(total[8:0]);
  endfunction

  function void check_response(logic [2:0] st, logic [31:0] nh, logic [7:0] idx,
                               logic [31:0] addr, logic [8:0] cnt);
    if (exp_status.size() == 0) begin
      $display("%0t: unexpected response, status %0d", $time, st);
      errors++;
      return;
    end
    if (st !== exp_status[0]) begin
      $display("%0t: status expected %0d actual %0d", $time, exp_status[0], st);
      errors++;
    end
    if (nh !== exp_handle[0]) begin
      $display("%0t: new_handle expected %h actual %h", $time, exp_handle[0], nh);
      errors++;
    end
    if (idx !== exp_index[0]) begin
      $display("%0t: block_index expected %0d actual %0d", $time, exp_index[0], idx);
      errors++;
    end
    if (addr !== exp_addr[0]) begin
      $display("%0t: block_address expected %h actual %h", $time, exp_addr[0], addr);
      errors++;
    end
    if (cnt !== exp_total[0]) begin
      $display("%0t: allocated_count expected %0d actual %0d", $time, exp_total[0], cnt);
      errors++;
    end
    void'(exp_status.pop_front());
    void'(exp_handle.pop_front());
    void'(exp_index.pop_front());
    void'(exp_addr.pop_front());
    void'(exp_total.pop_front());
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module tb;

  localparam int unsigned CYCLE_LIMIT = 2_000_000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [1:0]  operation_i;
  logic [31:0] handle_i;
  logic [15:0] salt_candidate_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [2:0]  status_o;
  logic [31:0] new_handle_o;
  logic [7:0]  block_index_o;
  logic [31:0] block_address_o;
  logic [8:0]  allocated_count_o;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i;
  logic [20:0] cfg_data_i;

  alloc_scoreboard pool;
  logic [31:0]     live_handles [$];
  int unsigned     cycles;
  int unsigned     burst_left;
  bit              stall_mode;

  salted_handle_block_allocator dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .handle_i,
    .salt_candidate_i, .out_valid_o, .out_ready_i, .status_o, .new_handle_o,
    .block_index_o, .block_address_o, .allocated_count_o, .cfg_valid_i,
    .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: alternates between phases of no stalling and random stalling.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i)
        pool.check_response(status_o, new_handle_o, block_index_o, block_address_o,
                            allocated_count_o);
      if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
      out_ready_i <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [20:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    pool.write_reg(idx, data);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    if (burst_left != 0) in_valid_i <= 1'b0;
    burst_left = 0;
    while (pool.pending() != 0) @(posedge clk_i);
    repeat (270) @(posedge clk_i);
  endtask

  task automatic send(logic [1:0] op, logic [31:0] h, logic [15:0] cand);
    if (burst_left == 0) begin
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    handle_i         <= h;
    salt_candidate_i <= cand;
    do @(posedge clk_i); while (!in_ready_o);
    pool.note_request(op, h, cand);
    if (op == shba_pkg::OP_ALLOC && pool.exp_status[$] == shba_pkg::ST_OK)
      live_handles.push_back(pool.exp_handle[$]);
    if (burst_left == 0) in_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] fresh_salt();
    logic [15:0] s;
    do s = 16'($urandom_range(1, 65535)); while (pool.salt_taken(s));
    return s;
  endfunction

  task automatic random_ops(int n);
    int          pick;
    int          k;
    logic [31:0] h;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        send(shba_pkg::OP_ALLOC, $urandom, fresh_salt());
      end else if (pick < 45) begin
        send(shba_pkg::OP_ALLOC, $urandom,
             (live_handles.size() != 0 && $urandom_range(0, 1)) ?
             live_handles[$urandom_range(0, live_handles.size() - 1)][31:16] : 16'h0);
      end else if (pick < 90 && live_handles.size() != 0) begin
        k = $urandom_range(0, live_handles.size() - 1);
        h = live_handles[k];
        if ($urandom_range(0, 1)) begin
          send(shba_pkg::OP_FREE, h, 16'($urandom));
          live_handles.delete(k);
        end else begin
          send(shba_pkg::OP_GET, h, 16'($urandom));
        end
      end else begin
        send(2'($urandom_range(0, 3)), ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom,
             16'($urandom));
      end
    end
  endtask

  task automatic fill_pool();
    while (pool.total < pool.active()) send(shba_pkg::OP_ALLOC, $urandom, fresh_salt());
  endtask

  initial begin
    pool = new();
    stall_mode = 1'b0;
    burst_left = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = shba_pkg::OP_ALLOC;
    handle_i = '0;
    salt_candidate_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = shba_pkg::CFG_BLOCK_COUNT;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send(shba_pkg::OP_ALLOC, 32'h0, 16'h0);
    send(shba_pkg::OP_ALLOC, 32'h0, 16'hFFFF);
    send(shba_pkg::OP_ALLOC, 32'hFFFF_FFFF, 16'hFFFF);
    send(shba_pkg::OP_ALLOC, 32'h0, 16'h0001);
    send(shba_pkg::OP_GET, 32'hFFFF_0000, 16'h0);
    send(shba_pkg::OP_GET, 32'h0001_1234, 16'h0);
    send(shba_pkg::OP_FREE, 32'h0, 16'h0);
    send(shba_pkg::OP_GET, 32'h0, 16'h0);
    send(2'd3, 32'hFFFF_FFFF, 16'hFFFF);
    send(shba_pkg::OP_GET, 32'h7777_0000, 16'h0);
    send(shba_pkg::OP_FREE, 32'h7777_0000, 16'h0);
    send(shba_pkg::OP_FREE, 32'hFFFF_0001, 16'h0);
    send(shba_pkg::OP_FREE, 32'hFFFF_0001, 16'h0);
    send(shba_pkg::OP_ALLOC, 32'h0, 16'h8000);
    send(shba_pkg::OP_GET, 32'h8000_0000, 16'h0);
    drain();

    write_reg(shba_pkg::CFG_BLOCK_COUNT, 21'd4);
    write_reg(shba_pkg::CFG_BLOCK_SIZE, 21'h1FFFF);
    write_reg(shba_pkg::CFG_DATA_OFFSET, 21'h1FFFFF);
    fill_pool();
    send(shba_pkg::OP_ALLOC, 32'h0, 16'h4242);
    send(shba_pkg::OP_GET, 32'h8000_0000, 16'h0);
    drain();
    random_ops(120);
    drain();

    write_reg(shba_pkg::CFG_BLOCK_COUNT, 21'd1);
    write_reg(shba_pkg::CFG_BLOCK_SIZE, 21'd1);
    write_reg(shba_pkg::CFG_DATA_OFFSET, 21'd0);
    random_ops(60);
    drain();

    write_reg(shba_pkg::CFG_BLOCK_COUNT, 21'd0);
    random_ops(20);
    drain();

    write_reg(shba_pkg::CFG_BLOCK_COUNT, 21'h1FF);
    write_reg(shba_pkg::CFG_BLOCK_SIZE, 21'h10000);
    write_reg(shba_pkg::CFG_DATA_OFFSET, 21'h100000);
    random_ops(200);
    drain();

    write_reg(shba_pkg::CFG_BLOCK_COUNT, 21'd24);
    write_reg(shba_pkg::CFG_BLOCK_SIZE, 21'd48);
    write_reg(shba_pkg::CFG_DATA_OFFSET, 21'd4096);
    random_ops(150);
    drain();

    if (pool.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

`default_nettype wire

FILE: salted_handle_block_allocator.f
design/shba_pkg.sv
design/shba_ram.sv
design/salted_handle_block_allocator.sv
tb/tb.sv
